[sv/mst_pkg.sv]
`default_nettype none
package mst_pkg;

   localparam int SEARCH_WINDOW = 512;
   localparam int SEEN_W = 13;
   localparam logic [7:0] SEP_CODE = 8'h2F;

   localparam int CSR_W = 21;
   localparam logic [2:0] CSR_CHAR_BITS = 3'd0;
   localparam logic [2:0] CSR_PARITY_SEED = 3'd1;
   localparam logic [2:0] CSR_SENTINELS = 3'd2;
   localparam logic [2:0] CSR_BOUNDS = 3'd3;
   localparam logic [2:0] CSR_ASCII_OFFSET = 3'd4;
   localparam logic [2:0] CSR_FIELD_COUNTS = 3'd5;
   localparam logic [2:0] CSR_MAX_CHARS = 3'd6;
   localparam logic [2:0] CSR_MAX_BITS = 3'd7;

   localparam logic [1:0] ST_CHAR = 2'd0;
   localparam logic [1:0] ST_GOOD = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'b001,
      PH_DECODE = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [3:0]  char_bits;
      logic        parity_seed;
      logic [20:0] sentinel_symbols;
      logic [13:0] value_bounds;
      logic [7:0]  ascii_offset;
      logic [7:0]  field_counts;
      logic [6:0]  max_chars;
      logic [9:0]  max_bits;
   } cfg_type;

   typedef struct packed {
      logic       fail;
      logic       done;
      logic       save;
      logic       marker_inc;
      logic [7:0] code;
   } verdict_type;

endpackage
`default_nettype wire

[sv/magstripe_track_decoder.sv]
// magnetic stripe track decoder
// req channel: one transaction per stripe bit (req_op 0, bit on req_data_bit,
// least significant first) or an end of swipe (req_op 1) that rearms the block.
// rsp channel: decoded characters (status 0), a good track (status 1) or a
// failure (status 2); rsp_last marks the final transaction of a swipe.
// csr port: write-only registers, taken on any edge with csr_we high, to be
// written only while no swipe transaction is outstanding.
// results: a result appears on rsp in the cycle after the req transaction that
// causes it; most bits produce no result.
// throughput: one req transaction every cycle while req_stall is low; the
// per-bit state update feeds the result register directly.
// reset: synchronous; the csr registers return to their defaults, the decoder hunts
// for a start sentinel and the result register is emptied.
// stall: a held result blocks req only while rsp_stall is high; a result
// being taken lets a new req transaction in during the same cycle.
`default_nettype none
module magstripe_track_decoder
   import mst_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_op,
   input  wire logic              req_data_bit,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_char_code,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;

   phase_type   phase_ff, phase_in;
   logic [6:0]  window_ff, window_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [6:0]  value_ff, value_in;
   logic [2:0]  bit_idx_ff, bit_idx_in;
   logic        parity_ff, parity_in;
   logic [6:0]  lrc_ff, lrc_in;
   logic [5:0]  marker_ff, marker_in;
   logic [6:0]  chars_ff, chars_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  code_ff, code_in;
   logic [1:0]  status_ff, status_in;
   logic        last_ff, last_in;

   logic        accept;
   logic [2:0]  width_n;
   logic [6:0]  hunt_window;
   logic [SEEN_W-1:0] seen_inc;
   logic [6:0]  hunt_data;
   logic [6:0]  value_next;
   logic        res_valid;
   logic [7:0]  res_code;
   logic [1:0]  res_status;
   verdict_type verdict;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_char_code = code_ff;
   assign rsp_status = status_ff;
   assign rsp_last = last_ff;

   mst_char_judge u_judge (
      .cfg          (cfg_ff),
      .value        (value_ff),
      .parity_bit   (req_data_bit),
      .parity_acc   (parity_ff),
      .marker_count (marker_ff),
      .lrc_acc      (lrc_ff),
      .chars_out    (chars_ff),
      .verdict      (verdict)
   );

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CHAR_BITS:    cfg_in.char_bits = csr_wdata[3:0];
            CSR_PARITY_SEED:  cfg_in.parity_seed = csr_wdata[0];
            CSR_SENTINELS:    cfg_in.sentinel_symbols = csr_wdata[20:0];
            CSR_BOUNDS:       cfg_in.value_bounds = csr_wdata[13:0];
            CSR_ASCII_OFFSET: cfg_in.ascii_offset = csr_wdata[7:0];
            CSR_FIELD_COUNTS: cfg_in.field_counts = csr_wdata[7:0];
            CSR_MAX_CHARS:    cfg_in.max_chars = csr_wdata[6:0];
            CSR_MAX_BITS:     cfg_in.max_bits = csr_wdata[9:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // per-bit decode
   always_comb begin
      if (cfg_ff.char_bits < 4'd2) begin
         width_n = 3'd1;
      end else if (cfg_ff.char_bits > 4'd8) begin
         width_n = 3'd7;
      end else begin
         width_n = 3'(cfg_ff.char_bits - 4'd1);
      end
      hunt_window = {req_data_bit, window_ff[6:1]};
      seen_inc = seen_ff + 1'b1;
      hunt_data = hunt_window >> (3'd7 - width_n);
      value_next = value_ff | (7'(req_data_bit) << bit_idx_ff);

      phase_in = phase_ff;
      window_in = window_ff;
      seen_in = seen_ff;
      value_in = value_ff;
      bit_idx_in = bit_idx_ff;
      parity_in = parity_ff;
      lrc_in = lrc_ff;
      marker_in = marker_ff;
      chars_in = chars_ff;
      res_valid = 1'b0;
      res_code = 8'd0;
      res_status = ST_FAIL;

      if (req_op) begin
         res_valid = (phase_ff != PH_DONE);
         phase_in = PH_HUNT;
         window_in = 7'd0;
         seen_in = '0;
         value_in = 7'd0;
         bit_idx_in = 3'd0;
         parity_in = cfg_ff.parity_seed;
         lrc_in = 7'd0;
         marker_in = 6'd0;
         chars_in = 7'd0;
      end else begin
         unique case (phase_ff)
            PH_HUNT: begin
               window_in = hunt_window;
               seen_in = seen_inc;
               if (seen_inc >= SEEN_W'(width_n) && seen_inc <= SEEN_W'(SEARCH_WINDOW)
                   && hunt_data == cfg_ff.sentinel_symbols[6:0]) begin
                  if (cfg_ff.max_bits == 10'd0) begin
                     res_valid = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_DECODE;
                     seen_in = SEEN_W'(width_n);
                     value_in = hunt_data;
                     bit_idx_in = width_n;
                     parity_in = cfg_ff.parity_seed ^ (^hunt_data);
                  end
               end else if (seen_inc >= SEEN_W'(SEARCH_WINDOW)) begin
                  res_valid = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            PH_DECODE: begin
               if (bit_idx_ff == 3'd0 && seen_ff >= SEEN_W'(cfg_ff.max_bits)) begin
                  res_valid = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  seen_in = seen_inc;
                  if (bit_idx_ff < width_n) begin
                     value_in = value_next;
                     parity_in = parity_ff ^ req_data_bit;
                     bit_idx_in = bit_idx_ff + 3'd1;
                  end else begin
                     value_in = 7'd0;
                     bit_idx_in = 3'd0;
                     parity_in = cfg_ff.parity_seed;
                     lrc_in = lrc_ff ^ value_ff;
                     if (verdict.marker_inc) begin
                        marker_in = marker_ff + 6'd1;
                     end
                     if (verdict.fail) begin
                        res_valid = 1'b1;
                        phase_in = PH_DONE;
                     end else if (verdict.done) begin
                        res_valid = 1'b1;
                        res_status = ST_GOOD;
                        phase_in = PH_DONE;
                     end else if (verdict.save) begin
                        res_valid = 1'b1;
                        res_status = ST_CHAR;
                        res_code = verdict.code;
                        chars_in = chars_ff + 7'd1;
                     end
                  end
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      code_in = code_ff;
      status_in = status_ff;
      last_in = last_ff;
      if (accept) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            code_in = res_code;
            status_in = res_status;
            last_in = (res_status != ST_CHAR);
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.char_bits <= 4'd5;
         cfg_ff.parity_seed <= 1'b1;
         cfg_ff.sentinel_symbols <= 21'd247435;
         cfg_ff.value_bounds <= 14'd1152;
         cfg_ff.ascii_offset <= 8'd48;
         cfg_ff.field_counts <= 8'd16;
         cfg_ff.max_chars <= 7'd40;
         cfg_ff.max_bits <= 10'd200;
         phase_ff <= PH_HUNT;
         window_ff <= 7'd0;
         seen_ff <= '0;
         value_ff <= 7'd0;
         bit_idx_ff <= 3'd0;
         parity_ff <= 1'b1;
         lrc_ff <= 7'd0;
         marker_ff <= 6'd0;
         chars_ff <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            phase_ff <= phase_in;
            window_ff <= window_in;
            seen_ff <= seen_in;
            value_ff <= value_in;
            bit_idx_ff <= bit_idx_in;
            parity_ff <= parity_in;
            lrc_ff <= lrc_in;
            marker_ff <= marker_in;
            chars_ff <= chars_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      status_ff <= status_in;
      last_ff <= last_in;
   end

endmodule
`default_nettype wire

[sv/mst_char_judge.sv]
`default_nettype none
module mst_char_judge
   import mst_pkg::*;
(
   input  wire cfg_type     cfg,
   input  wire logic [6:0]  value,
   input  wire logic        parity_bit,
   input  wire logic        parity_acc,
   input  wire logic [5:0]  marker_count,
   input  wire logic [6:0]  lrc_acc,
   input  wire logic [6:0]  chars_out,
   output verdict_type      verdict
);

   logic [5:0] nf;
   logic [5:0] ns_end;
   logic [5:0] es_count;
   logic [6:0] ss;
   logic [6:0] fs;
   logic [6:0] es;
   logic [6:0] vmin;
   logic [6:0] vmax;
   logic [6:0] limit;
   logic       bad;
   logic       sep;
   logic [7:0] data_code;

   always_comb begin
      nf = {2'b00, cfg.field_counts[3:0]};
      ns_end = nf + {2'b00, cfg.field_counts[7:4]};
      es_count = ns_end + 6'd1;
      ss = cfg.sentinel_symbols[6:0];
      fs = cfg.sentinel_symbols[13:7];
      es = cfg.sentinel_symbols[20:14];
      vmin = cfg.value_bounds[6:0];
      vmax = cfg.value_bounds[13:7];
      limit = cfg.max_chars - 7'd1;
      data_code = {1'b0, value} + cfg.ascii_offset;

      bad = 1'b0;
      sep = 1'b0;
      verdict.done = 1'b0;
      verdict.save = 1'b0;
      verdict.marker_inc = 1'b0;

      // ordering: start, format codes, separators, end, lrc, data
      priority if (marker_count == 6'd0 && value == ss) begin
         verdict.marker_inc = 1'b1;
      end else if (marker_count != 6'd0 && marker_count <= nf) begin
         verdict.marker_inc = 1'b1;
         verdict.save = 1'b1;
      end else if (value == fs && marker_count > nf && marker_count <= ns_end) begin
         verdict.marker_inc = 1'b1;
         verdict.save = 1'b1;
         sep = 1'b1;
      end else if (value == es && marker_count == es_count) begin
         verdict.marker_inc = 1'b1;
      end else if (marker_count == es_count + 6'd1 && lrc_acc == value) begin
         verdict.done = 1'b1;
      end else if (marker_count > nf && marker_count <= es_count
                   && value >= vmin && value <= vmax) begin
         verdict.save = 1'b1;
      end else begin
         bad = 1'b1;
      end

      verdict.fail = (parity_acc != parity_bit) || bad || (chars_out >= limit);
      verdict.code = sep ? SEP_CODE : data_code;
   end

endmodule
`default_nettype wire
